// ----- sv/chfa_pkg.sv -----
// ----------------------------------------------------------------------------
// chfa_pkg: shared types and constants for the compass heading block
// Fixed-point formats, the CORDIC arctangent table and the heading limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package chfa_pkg;

    // payload field types
    typedef logic signed [15:0] t_reading;
    typedef logic        [14:0] t_heading;
    typedef logic signed [14:0] t_decl;

    // internal datapath types
    // axis: reading scaled by 2^16 plus headroom for the CORDIC gain
    typedef logic signed [34:0] t_axis;
    // angle in 2^-16 degree, covers -180..+280 degrees before the wrap
    typedef logic signed [25:0] t_angle;
    // rounded angle in 1/64 degree
    typedef logic signed [15:0] t_qangle;
    // heading sum before wrapping
    typedef logic signed [16:0] t_hsum;

    localparam int MAX_ITER = 24;

    localparam t_angle DEG_180    = 26'sd11796480;
    localparam t_angle DEG_360    = 26'sd23592960;
    localparam t_angle ROUND_HALF = 26'sd512;

    localparam t_decl DECL_LIMIT_P = 15'sd11520;
    localparam t_decl DECL_LIMIT_N = -15'sd11520;

    localparam t_hsum FULL_TURN = 17'sd23040;
    localparam t_hsum HSUM_ZERO = 17'sd0;

    // atan(2^-i) in 2^-16 degree, rounded to nearest
    localparam t_angle ATAN_TABLE [0:MAX_ITER-1] = '{
        26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
        26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
        26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
        26'sd917,     26'sd458,     26'sd229,    26'sd115,
        26'sd57,      26'sd29,      26'sd14,     26'sd7,
        26'sd4,       26'sd2,       26'sd1,      26'sd0
    };

endpackage

`default_nettype wire

// ----- sv/chfa_axes_if.sv -----
// ----------------------------------------------------------------------------
// chfa_axes_if: input channel carrying one X/Y reading pair per beat
// Valid/ready handshake; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface chfa_axes_if;
    logic                valid;
    logic                ready;
    chfa_pkg::t_reading  x_reading;
    chfa_pkg::t_reading  y_reading;

    modport source (output valid, output x_reading, output y_reading, input ready);
    modport sink   (input valid, input x_reading, input y_reading, output ready);
endinterface

`default_nettype wire

// ----- sv/chfa_heading_if.sv -----
// ----------------------------------------------------------------------------
// chfa_heading_if: output channel carrying one heading per beat
// Valid/ready handshake; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface chfa_heading_if;
    logic                valid;
    logic                ready;
    chfa_pkg::t_heading  heading;

    modport source (output valid, output heading, input ready);
    modport sink   (input valid, input heading, output ready);
endinterface

`default_nettype wire

// ----- sv/compass_heading_from_axes.sv -----
// ----------------------------------------------------------------------------
// compass_heading_from_axes: magnetometer heading by pipelined CORDIC atan2
// Vectoring CORDIC on the X/Y readings, rounding to 1/64 degree, declination
// add and wrap into 0..360 degrees.
//
//   channel      dir   payload                       handshake
//   i_axes       in    x_reading, y_reading (s16)    valid / ready
//   o_heading    out   heading (u15, 1/64 deg)       valid / ready
//   cfg          in    i_cfg_wdata (s15 declination) i_cfg_we
//
// one beat per cycle sustained while the output is not stalled; the stages are:
// one prep stage, one register per CORDIC micro-rotation, round, heading.
// each stage holds its own valid and advances when empty or when the stage
// after it moves, so bubbles collapse and a stall loses nothing.
// synchronous active-low reset clears valids and sets declination to 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module compass_heading_from_axes #(
    parameter int ITERATIONS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  chfa_pkg::t_decl     i_cfg_wdata,
    chfa_axes_if.sink           i_axes,
    chfa_heading_if.source      o_heading
);
    import chfa_pkg::*;

    localparam int N    = (ITERATIONS > MAX_ITER) ? MAX_ITER : ITERATIONS;
    localparam int LAST = N + 2;

    // declination register, saturated on write
    t_decl r_decl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decl <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_wdata > DECL_LIMIT_P) begin
                r_decl <= DECL_LIMIT_P;
            end else if (i_cfg_wdata < DECL_LIMIT_N) begin
                r_decl <= DECL_LIMIT_N;
            end else begin
                r_decl <= i_cfg_wdata;
            end
        end
    end

    // per-stage valids and advance enables
    logic [LAST:0] r_v;
    logic [LAST:0] adv;

    assign adv[LAST] = !r_v[LAST] || o_heading.ready;

    genvar g;
    generate
        for (g = 0; g < LAST; g++) begin : g_adv
            assign adv[g] = !r_v[g] || adv[g+1];
        end
    endgenerate

    assign i_axes.ready = adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) begin
                r_v[0] <= i_axes.valid;
            end
            for (int k = 1; k <= LAST; k++) begin
                if (adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // cordic datapath registers
    t_axis  r_x  [0:N];
    t_axis  r_y  [0:N];
    t_angle r_z  [0:N];
    logic   r_zf [0:N];

    // prep: scale by 2^16, fold the left half plane onto the right
    t_axis  n_x0;
    t_axis  n_y0;
    t_angle n_z0;
    t_axis  w_xs;
    t_axis  w_ys;

    always_comb begin
        w_xs = {{3{i_axes.x_reading[15]}}, i_axes.x_reading, 16'h0000};
        w_ys = {{3{i_axes.y_reading[15]}}, i_axes.y_reading, 16'h0000};
        if (i_axes.x_reading[15]) begin
            n_x0 = -w_xs;
            n_y0 = -w_ys;
            n_z0 = DEG_180;
        end else begin
            n_x0 = w_xs;
            n_y0 = w_ys;
            n_z0 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_x[0]  <= n_x0;
            r_y[0]  <= n_y0;
            r_z[0]  <= n_z0;
            r_zf[0] <= (i_axes.x_reading == '0) && (i_axes.y_reading == '0);
        end
    end

    // one micro-rotation per stage
    generate
        for (g = 0; g < N; g++) begin : g_iter
            t_axis  w_dx;
            t_axis  w_dy;
            t_axis  n_x;
            t_axis  n_y;
            t_angle n_z;

            assign w_dx = r_y[g] >>> g;
            assign w_dy = r_x[g] >>> g;

            always_comb begin
                if (!r_y[g][34]) begin
                    n_x = r_x[g] + w_dx;
                    n_y = r_y[g] - w_dy;
                    n_z = r_z[g] + ATAN_TABLE[g];
                end else begin
                    n_x = r_x[g] - w_dx;
                    n_y = r_y[g] + w_dy;
                    n_z = r_z[g] - ATAN_TABLE[g];
                end
            end

            always_ff @(posedge i_clk) begin
                if (adv[g+1]) begin
                    r_x[g+1]  <= n_x;
                    r_y[g+1]  <= n_y;
                    r_z[g+1]  <= n_z;
                    r_zf[g+1] <= r_zf[g];
                end
            end
        end
    endgenerate

    // wrap into (-180, 180] and round to 1/64 degree, half up
    t_qangle r_q;
    t_angle  w_zw;
    t_angle  w_zr;

    always_comb begin
        w_zw = (r_z[N] > DEG_180) ? (r_z[N] - DEG_360) : r_z[N];
        w_zr = w_zw + ROUND_HALF;
    end

    always_ff @(posedge i_clk) begin
        if (adv[N+1]) begin
            r_q <= r_zf[N] ? '0 : w_zr[25:10];
        end
    end

    // add declination and wrap once into 0..360 degrees
    t_heading r_h;
    t_hsum    w_sum;
    t_hsum    n_h;

    always_comb begin
        w_sum = {r_q[15], r_q} + {{2{r_decl[14]}}, r_decl};
        if (w_sum < HSUM_ZERO) begin
            n_h = w_sum + FULL_TURN;
        end else if (w_sum > FULL_TURN) begin
            n_h = w_sum - FULL_TURN;
        end else begin
            n_h = w_sum;
        end
        if (n_h < HSUM_ZERO) begin
            n_h = HSUM_ZERO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[LAST]) begin
            r_h <= n_h[14:0];
        end
    end

    assign o_heading.valid   = r_v[LAST];
    assign o_heading.heading = r_h;

endmodule

`default_nettype wire

// ----- sv/chfa_checker.sv -----
// ----------------------------------------------------------------------------
// chfa_checker: port-level checks for compass_heading_from_axes
// Watches the handshakes and heading range; bound onto the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chfa_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input chfa_pkg::t_heading i_heading
);
    import chfa_pkg::*;

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output beat valid right after reset");

    // heading stays within one full turn
    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_heading <= 15'd23040))
        else $error("heading beyond 360 degrees");

    // with no result pending an offered input beat must be taken
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !i_out_valid) |-> i_in_ready)
        else $error("input stalled while output stage empty");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_heading)))
        else $error("stalled output beat changed or dropped");

endmodule

bind compass_heading_from_axes chfa_checker u_chfa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_axes.valid),
    .i_in_ready  (i_axes.ready),
    .i_out_valid (o_heading.valid),
    .i_out_ready (o_heading.ready),
    .i_heading   (o_heading.heading)
);

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for compass_heading_from_axes
// Drives X/Y reading pairs through the valid/ready input channel, predicts
// each heading with an independent CORDIC atan2 model in 64-bit integers,
// and checks every output beat in order. Covers axis extremes, declination
// saturation and wrap, back-pressure and random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import chfa_pkg::*;

    localparam int N_ITER    = 16;
    localparam int LATENCY   = N_ITER + 3;
    localparam int ATAN_LEN  = 24;
    localparam int CHUNKS    = 13;
    localparam int CHUNK_LEN = 100;

    // angles in 2^-16 degree, headings in 1/64 degree
    localparam longint ANG_ONE   = 65536;
    localparam longint ANG_180   = 180 * ANG_ONE;
    localparam longint ANG_360   = 360 * ANG_ONE;
    localparam longint TURN_Q    = 23040;
    localparam longint DECL_SAT  = 11520;

    // atan(2^-i) in 2^-16 degree
    localparam longint ATAN_STEP [0:ATAN_LEN-1] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    // declination corners, including values past the saturation limit
    localparam t_decl DECL_CORNERS [0:4] = '{
        t_decl'(11520), t_decl'(-11520), t_decl'(16383), t_decl'(-16384),
        t_decl'(-11521)
    };

    logic   i_clk = 1'b0;
    logic   i_rst_n;
    logic   i_cfg_we;
    t_decl  i_cfg_wdata;

    chfa_axes_if    axes ();
    chfa_heading_if hdg ();

    t_heading pending_headings [$];
    t_decl    decl_model;

    int  err_count     = 0;
    int  pairs_sent    = 0;
    int  headings_seen = 0;
    int  decl_writes   = 0;
    int  input_stalls  = 0;
    int  hold_req      = 0;
    bit  send_idle_on  = 1'b0;
    bit  recv_idle_on  = 1'b0;

    compass_heading_from_axes #(
        .ITERATIONS (N_ITER)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_axes      (axes),
        .o_heading   (hdg)
    );

    // clock
    always #2 i_clk = ~i_clk;

    // heading predictor: vectoring cordic, round, declination add and wrap
    function automatic t_heading predict_heading(t_reading x, t_reading y, t_decl decl);
        longint ax, ay, dx, dy, ang, q, d, h;
        ang = 0;
        if (x != 0 || y != 0) begin
            ax = longint'(x) * ANG_ONE;
            ay = longint'(y) * ANG_ONE;
            // left half plane: flip into the right half, start at 180
            if (ax < 0) begin
                ax  = -ax;
                ay  = -ay;
                ang = ANG_180;
            end
            for (int i = 0; i < N_ITER && i < ATAN_LEN; i++) begin
                dx = ay >>> i;
                dy = ax >>> i;
                if (ay >= 0) begin
                    ax  = ax + dx;
                    ay  = ay - dy;
                    ang = ang + ATAN_STEP[i];
                end else begin
                    ax  = ax - dx;
                    ay  = ay + dy;
                    ang = ang - ATAN_STEP[i];
                end
            end
            if (ang > ANG_180)
                ang = ang - ANG_360;
        end
        // round half up to 1/64 degree
        q = ((ang + 512 + ANG_360) >>> 10) - TURN_Q;
        d = longint'(decl);
        if (d > DECL_SAT)
            d = DECL_SAT;
        if (d < -DECL_SAT)
            d = -DECL_SAT;
        h = q + d;
        if (h < 0)
            h = h + TURN_Q;
        if (h > TURN_Q)
            h = h - TURN_Q;
        if (h < 0)
            h = 0;
        return t_heading'(h);
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    function automatic t_reading random_reading();
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 4))
                    0: return t_reading'(-32768);
                    1: return t_reading'(32767);
                    2: return t_reading'(0);
                    3: return t_reading'(-1);
                    default: return t_reading'(1);
                endcase
            end
            1: return t_reading'(int'($urandom_range(0, 16)) - 8);
            default: return t_reading'($urandom);
        endcase
    endfunction

    // send one reading pair, optionally after an idle gap
    task automatic send_reading(input t_reading x, input t_reading y);
        int gap;
        gap = (send_idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            axes.valid     <= 1'b0;
            axes.x_reading <= t_reading'($urandom);
            axes.y_reading <= t_reading'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        axes.valid     <= 1'b1;
        axes.x_reading <= x;
        axes.y_reading <= y;
        do
            @(posedge i_clk);
        while (!axes.ready);
        pending_headings.push_back(predict_heading(x, y, decl_model));
        pairs_sent++;
    endtask

    // stop offering and wait until every expected heading has come back
    task automatic drain_headings();
        axes.valid <= 1'b0;
        while (pending_headings.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_declination(input t_decl d);
        drain_headings();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= d;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        decl_model  = d;
        decl_writes++;
    endtask

    // axis extremes, zero vector and the four quadrant boundaries
    task automatic test_axis_extremes();
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        send_reading(0, 0);
        send_reading(32767, 0);
        send_reading(-32768, 0);
        send_reading(0, 32767);
        send_reading(0, -32768);
        send_reading(32767, 32767);
        send_reading(-32768, -32768);
        send_reading(-32768, 32767);
        send_reading(32767, -32768);
        send_reading(-1, 0);
        send_reading(-1, -1);
        send_reading(1, -1);
        send_reading(-1, 1);
        send_reading(-32768, -1);
    endtask

    // declination limits, saturation and wrap at 0 and 360 degrees
    task automatic test_declination_corners();
        foreach (DECL_CORNERS[k]) begin
            write_declination(DECL_CORNERS[k]);
            send_reading(0, 0);
            send_reading(-32768, 0);
        end
    endtask

    // long receiver hold-off fills the pipe, then a full sender pause
    task automatic test_backpressure();
        write_declination(t_decl'(0));
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        hold_req     = 300;
        repeat (80) send_reading(random_reading(), random_reading());
        drain_headings();
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        repeat (20) send_reading(random_reading(), random_reading());
        drain_headings();
        repeat (20) send_reading(random_reading(), random_reading());
    endtask

    // random readings in chunks, each with its own declination and idling
    task automatic test_random_readings();
        t_decl d;
        for (int c = 0; c < CHUNKS; c++) begin
            case ($urandom_range(0, 5))
                0: d = t_decl'($urandom);
                1: d = ($urandom_range(0, 1) == 1) ? t_decl'(11520) : t_decl'(-11520);
                default: d = t_decl'(int'($urandom_range(0, 23040)) - 11520);
            endcase
            write_declination(d);
            send_idle_on = (c % 4 != 0) && ($urandom_range(0, 3) != 0);
            recv_idle_on = (c % 4 != 1) && ($urandom_range(0, 3) != 0);
            repeat (CHUNK_LEN) send_reading(random_reading(), random_reading());
        end
    endtask

    // output side: random stalls and the requested long hold-off
    initial begin
        int stall_left;
        stall_left = 0;
        hdg.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req > 0) begin
                stall_left = hold_req;
                hold_req   = 0;
            end
            if (stall_left > 0) begin
                hdg.ready <= 1'b0;
                stall_left--;
            end else if (recv_idle_on && $urandom_range(0, 4) == 0) begin
                hdg.ready <= 1'b0;
                stall_left = pick_gap();
            end else begin
                hdg.ready <= 1'b1;
            end
        end
    end

    // heading checker
    always @(posedge i_clk) begin
        if (i_rst_n && axes.valid && !axes.ready)
            input_stalls++;
        if (i_rst_n && hdg.valid && hdg.ready) begin
            headings_seen++;
            if (pending_headings.size() == 0) begin
                $error("heading beat with nothing expected: actual %0d", hdg.heading);
                err_count++;
            end else begin
                t_heading want;
                want = pending_headings.pop_front();
                if (hdg.heading !== want) begin
                    $error("heading mismatch: expected %0d, actual %0d", want, hdg.heading);
                    err_count++;
                end
            end
        end
    end

    // run limit
    initial begin
        #4000000;
        $display("tb failed");
        $finish;
    end

    // main sequence
    initial begin
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_wdata    <= '0;
        axes.valid     <= 1'b0;
        axes.x_reading <= '0;
        axes.y_reading <= '0;
        decl_model     = t_decl'(0);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_axis_extremes();
        test_declination_corners();
        test_backpressure();
        test_random_readings();

        drain_headings();
        repeat (LATENCY + 8) @(posedge i_clk);
        if (pending_headings.size() != 0) begin
            $error("%0d expected headings never arrived", pending_headings.size());
            err_count++;
        end

        $display("covered %0d reading pairs and %0d heading beats over %0d declination writes",
                 pairs_sent, headings_seen, decl_writes);
        $display("input channel stalled for %0d cycles under output back-pressure",
                 input_stalls);
        if (err_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// ----- compass_heading_from_axes.f -----
sv/chfa_pkg.sv
sv/chfa_axes_if.sv
sv/chfa_heading_if.sv
sv/compass_heading_from_axes.sv
sv/chfa_checker.sv
tb/tb.sv
